// ===== hdl/sv32_page_mapper_defines.svh =====
// Assertion macros for the sv32 page mapper.
`ifndef SV32_PAGE_MAPPER_DEFINES_SVH
`define SV32_PAGE_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define SV32PM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define SV32PM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SV32PM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SV32PM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/sv32pm_pkg.sv =====
// Types and constants shared by the sv32 page mapper.
package sv32pm_pkg;

	localparam int unsigned ROOT_SLOTS = 1024;
	localparam int unsigned PAGE_BYTES = 4096;
	localparam int unsigned SLOT_W     = $clog2(ROOT_SLOTS);
	localparam int unsigned OFFSET_W   = $clog2(PAGE_BYTES);
	localparam int unsigned PPN_W      = 20;
	localparam int unsigned FLAGS_W    = 10;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FREE_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_END  = 1'd1;

	localparam logic [PPN_W-1:0] FREE_END_RESET = '1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNALIGNED_VA = 2'd1,
		ST_UNALIGNED_PA = 2'd2,
		ST_NO_TABLE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0]        virt_addr;
		logic [31:0]        phys_addr;
		logic [FLAGS_W-1:0] perm_flags;
	} map_req_t;

	typedef struct packed {
		status_t            status;
		logic               table_allocated;
		logic [PPN_W-1:0]   leaf_table_ppn;
		logic [SLOT_W-1:0]  leaf_slot;
		logic [31:0]        leaf_pte;
	} map_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [PPN_W-1:0] ppn;
	} root_entry_t;

endpackage

// ===== hdl/sv32pm_root_ram.sv =====
// Root page table storage: one write port, one read port, registered read data.
module sv32pm_root_ram
	import sv32pm_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output root_entry_t       rd_data,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  root_entry_t       wr_data
);

	root_entry_t mem [ROOT_SLOTS];
	root_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/sv32_page_mapper.sv =====
// Sv32 page mapper top level: root table lookup, table page allocation, leaf entry build.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   map_req_t  (virt_addr, phys_addr, perm_flags)
//  out      source     out_valid/out_stall map_rsp_t  (status .. leaf_pte)
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data (free_base, free_end)
//
// A transaction is accepted with the root read, then checked/allocated with the root write;
// in_stall holds off the next request meanwhile (read-modify-write of one root table entry).
// After reset a clearing pass over all 1024 root entries empties the root table; in_stall is high.
// cfg writes are taken at any time, including during the clearing pass.
// The output register holds a result under out_stall; the lookup cycle waits for it.
`include "sv32_page_mapper_defines.svh"

module sv32_page_mapper
	import sv32pm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  map_req_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output map_rsp_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PPN_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR  = 3'b001,
		S_IDLE   = 3'b010,
		S_LOOKUP = 3'b100
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] clr_addr_q;
	logic [PPN_W-1:0]  next_free_q;
	logic [PPN_W-1:0]  free_end_q;
	map_req_t          req_s1;
	logic              out_valid_q;
	map_rsp_t          out_data_q;

	logic              in_accept;
	logic              cfg_write;
	logic              out_free;
	root_entry_t       rd_entry;
	logic              ram_wr_en;
	logic [SLOT_W-1:0] ram_wr_addr;
	root_entry_t       ram_wr_data;
	logic              need_table;
	logic              do_alloc;
	map_rsp_t          rsp;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;

	sv32pm_root_ram u_root_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (in_data.virt_addr[31 -: SLOT_W]),
		.rd_data (rd_entry),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	always_comb begin
		rsp        = '0;
		need_table = 1'b0;
		do_alloc   = 1'b0;
		if (req_s1.virt_addr[OFFSET_W-1:0] != '0) begin
			rsp.status = ST_UNALIGNED_VA;
		end else if (req_s1.phys_addr[OFFSET_W-1:0] != '0) begin
			rsp.status = ST_UNALIGNED_PA;
		end else begin
			need_table = !rd_entry.valid;
			if (need_table && (next_free_q >= free_end_q)) begin
				rsp.status = ST_NO_TABLE;
			end else begin
				do_alloc            = need_table;
				rsp.status          = ST_OK;
				rsp.table_allocated = need_table;
				rsp.leaf_table_ppn  = need_table ? next_free_q : rd_entry.ppn;
				rsp.leaf_slot       = req_s1.virt_addr[OFFSET_W +: SLOT_W];
				rsp.leaf_pte        = {2'b00, req_s1.phys_addr[31:OFFSET_W], FLAGS_W'(0)}
				                    | {{(32-FLAGS_W){1'b0}}, req_s1.perm_flags}
				                    | 32'd1;
			end
		end
	end

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = clr_addr_q;
		ram_wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				ram_wr_en = 1'b1;
			end
			S_LOOKUP: begin
				ram_wr_en         = do_alloc && out_free;
				ram_wr_addr       = req_s1.virt_addr[31 -: SLOT_W];
				ram_wr_data.valid = 1'b1;
				ram_wr_data.ppn   = next_free_q;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			next_free_q <= '0;
			free_end_q  <= FREE_END_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (do_alloc) begin
							next_free_q <= next_free_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (cfg_write) begin
				case (cfg_index)
					CFG_FREE_BASE: next_free_q <= cfg_data;
					CFG_FREE_END:  free_end_q  <= cfg_data;
					default:       free_end_q  <= free_end_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1 <= in_data;
		end
		if (state_q == S_LOOKUP && out_free) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SV32PM_ASSERT(a_alloc_only_ok, clk, arst_n, (out_valid && out_data.table_allocated) |-> (out_data.status == ST_OK), "table allocated on a failed transaction")
	`SV32PM_ASSERT(a_error_clears_pte, clk, arst_n, (out_valid && out_data.status != ST_OK) |-> (out_data.leaf_pte == '0), "leaf entry nonzero on a failed transaction")
	`SV32PM_ASSERT(a_alloc_bumps, clk, arst_n, (state_q == S_LOOKUP && out_free && do_alloc && !cfg_write) |=> (next_free_q == $past(next_free_q) + 1'b1), "allocator did not advance")
	`SV32PM_ASSERT(a_alloc_below_end, clk, arst_n, (state_q == S_LOOKUP && do_alloc) |-> (next_free_q < free_end_q), "allocation past the free end")
	`SV32PM_ASSERT(a_no_accept_in_clear, clk, arst_n, (state_q == S_CLEAR) |-> in_stall, "transaction accepted during table clear")

endmodule

// ===== tb/sv/tb_sv32_page_mapper.sv =====
// Self-checking testbench for sv32_page_mapper: directed and random map requests, leaf entries predicted and compared.
module tb_sv32_page_mapper
	import sv32pm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_SLACK  = 8;
	localparam int PHASE_ITEMS  = 270;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	map_req_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	map_rsp_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FREE_BASE;
	logic [PPN_W-1:0]     cfg_data = '0;

	sv32_page_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state
	root_entry_t        root_tbl [ROOT_SLOTS];
	logic [PPN_W:0]     alloc_next;
	logic [PPN_W-1:0]   alloc_end;

	map_req_t           map_backlog [$];
	map_rsp_t           leaf_writes_due [$];
	logic [SLOT_W-1:0]  mapped_roots [$];

	int idle_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int in_gap = 0;
	int stall_gap = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic map_rsp_t build_leaf(map_req_t req);
		map_rsp_t          rsp;
		logic [SLOT_W-1:0] root_idx;
		rsp = '0;
		root_idx = req.virt_addr[31:22];
		if (req.virt_addr[OFFSET_W-1:0] != '0) begin
			rsp.status = ST_UNALIGNED_VA;
		end else if (req.phys_addr[OFFSET_W-1:0] != '0) begin
			rsp.status = ST_UNALIGNED_PA;
		end else if (!root_tbl[root_idx].valid && alloc_next >= {1'b0, alloc_end}) begin
			rsp.status = ST_NO_TABLE;
		end else begin
			if (!root_tbl[root_idx].valid) begin
				root_tbl[root_idx].valid = 1'b1;
				root_tbl[root_idx].ppn = alloc_next[PPN_W-1:0];
				alloc_next = alloc_next + 1'b1;
				rsp.table_allocated = 1'b1;
			end
			rsp.status = ST_OK;
			rsp.leaf_table_ppn = root_tbl[root_idx].ppn;
			rsp.leaf_slot = req.virt_addr[21:12];
			rsp.leaf_pte = {2'b0, req.phys_addr[31:12], 10'b0} | {22'b0, req.perm_flags} | 32'd1;
		end
		return rsp;
	endfunction

	task automatic push_map(input logic [31:0] va, input logic [31:0] pa,
			input logic [FLAGS_W-1:0] flags);
		map_req_t req;
		req.virt_addr = va;
		req.phys_addr = pa;
		req.perm_flags = flags;
		map_backlog.push_back(req);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PPN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FREE_BASE)
			alloc_next = {1'b0, val};
		else
			alloc_end = val;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (map_backlog.size() != 0 || in_valid || leaf_writes_due.size() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				leaf_writes_due.push_back(build_leaf(in_data));
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
					in_valid <= 1'b0;
					in_gap <= $urandom_range(6);
				end else if (map_backlog.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= map_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		map_rsp_t want;
		int       hold_n;
		int       gap_n;
		logic     stall_n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_gap <= 0;
			hold_left <= 0;
		end else begin
			hold_n = hold_left;
			gap_n = stall_gap;
			stall_n = 1'b0;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (leaf_writes_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected transaction: status=%0d table=%h slot=%h pte=%h",
							out_data.status, out_data.leaf_table_ppn, out_data.leaf_slot,
							out_data.leaf_pte);
					mismatches++;
				end else begin
					want = leaf_writes_due.pop_front();
					if (out_data.status !== want.status ||
							out_data.table_allocated !== want.table_allocated ||
							out_data.leaf_table_ppn !== want.leaf_table_ppn ||
							out_data.leaf_slot !== want.leaf_slot ||
							out_data.leaf_pte !== want.leaf_pte) begin
						if (mismatches < 10)
							$display({"transaction %0d: expected status=%0d alloc=%0d table=%h ",
								"slot=%h pte=%h, got status=%0d alloc=%0d table=%h slot=%h pte=%h"},
								results_seen, want.status, want.table_allocated,
								want.leaf_table_ppn, want.leaf_slot, want.leaf_pte,
								out_data.status, out_data.table_allocated,
								out_data.leaf_table_ppn, out_data.leaf_slot, out_data.leaf_pte);
						mismatches++;
					end
				end
				if (results_seen == 300 || results_seen == 800)
					hold_n = HOLD_CYCLES;
			end
			if (hold_n != 0) begin
				stall_n = 1'b1;
				hold_n--;
			end else if (gap_n != 0) begin
				stall_n = 1'b1;
				gap_n--;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				stall_n = 1'b1;
				gap_n = $urandom_range(6);
			end
			out_stall <= stall_n;
			hold_left <= hold_n;
			stall_gap <= gap_n;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int                unsigned base_ppn;
		int                unsigned end_ppn;
		logic [31:0]       va;
		logic [31:0]       pa;
		logic [SLOT_W-1:0] root;
		int                pick;
		foreach (root_tbl[i])
			root_tbl[i] = '0;
		alloc_next = '0;
		alloc_end = FREE_END_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, both alignment errors and their priority, table reuse
		@(negedge clk);
		idle_pct = 15;
		push_map(32'h0000_0000, 32'h0000_0000, 10'h000);
		push_map(32'h0000_1000, 32'hFFFF_F000, 10'h3FF);
		push_map(32'hFFFF_F000, 32'hFFFF_F000, 10'h3FF);
		push_map(32'hFFC0_0000, 32'h0000_0000, 10'h155);
		push_map(32'h0000_0001, 32'h0000_0000, 10'h000);
		push_map(32'h0000_0800, 32'h0000_1000, 10'h001);
		push_map(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
		push_map(32'h0040_0000, 32'h0000_0FFF, 10'h2AA);
		push_map(32'h0040_0000, 32'h0000_0001, 10'h000);
		push_map(32'h0040_0000, 32'h8000_0000, 10'h200);
		wait_drained();

		// allocator runs up to the end bound, then exhausts
		write_reg(CFG_FREE_BASE, 20'hFFFFD);
		write_reg(CFG_FREE_END, 20'hFFFFF);
		@(negedge clk);
		push_map(32'h4000_0000, 32'h1234_5000, 10'h001);
		push_map(32'h4040_0000, 32'h0ABC_D000, 10'h0CF);
		push_map(32'h4080_0000, 32'h5555_5000, 10'h3FF);
		push_map(32'h4000_2000, 32'hAAAA_A000, 10'h0C3);
		wait_drained();

		// base above end, then base equal to end
		write_reg(CFG_FREE_BASE, 20'h00010);
		write_reg(CFG_FREE_END, 20'h00000);
		@(negedge clk);
		push_map(32'h40C0_0000, 32'h0000_2000, 10'h00F);
		push_map(32'h0000_3000, 32'h0000_4000, 10'h0F0);
		wait_drained();
		write_reg(CFG_FREE_END, 20'h00010);
		@(negedge clk);
		push_map(32'h4100_0000, 32'h0000_5000, 10'h01F);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					base_ppn = $urandom_range(20'hFFFFF);
					end_ppn = (base_ppn + 48 > 20'hFFFFF) ? 20'hFFFFF : base_ppn + 48;
				end
				1: begin
					base_ppn = 0;
					end_ppn = 20'hFFFFF;
				end
				2: begin
					base_ppn = 20'hFFFFF;
					end_ppn = 20'hFFFFF;
				end
				3: begin
					base_ppn = $urandom_range(20'hFFFFF);
					end_ppn = $urandom_range(20'hFFFFF);
				end
				default: begin
					base_ppn = $urandom_range(20'hFFFFF);
					end_ppn = (base_ppn + 20 > 20'hFFFFF) ? 20'hFFFFF : base_ppn + 20;
				end
			endcase
			write_reg(CFG_FREE_BASE, base_ppn[PPN_W-1:0]);
			write_reg(CFG_FREE_END, end_ppn[PPN_W-1:0]);
			@(negedge clk);
			case (ph)
				0: idle_pct = 20;
				2: idle_pct = 40;
				3: idle_pct = 10;
				default: idle_pct = 0;
			endcase
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (mapped_roots.size() == 0 || $urandom_range(99) < 30) begin
					root = SLOT_W'($urandom_range(ROOT_SLOTS - 1));
					mapped_roots.push_back(root);
				end else begin
					root = mapped_roots[$urandom_range(mapped_roots.size() - 1)];
				end
				va = {root, 10'($urandom), 12'h000};
				pa = {20'($urandom), 12'h000};
				if (pick < 8) begin
					va = $urandom;
					if (va[11:0] == '0)
						va[0] = 1'b1;
				end else if (pick < 14) begin
					pa = $urandom;
					if (pa[11:0] == '0)
						pa[11] = 1'b1;
				end
				push_map(va, pa, 10'($urandom));
			end
			wait_drained();
		end

		if (mismatches == 0 && leaf_writes_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sv32pm_pkg.sv
hdl/sv32pm_root_ram.sv
hdl/sv32_page_mapper.sv
tb/sv/tb_sv32_page_mapper.sv
